// ===== design/mbrtu_pkg.sv =====
// Shared types, codes and the CRC-16 byte update for the Modbus RTU response framer.
// No dependencies; every design file imports this package.
package mbrtu_pkg;

  localparam int unsigned JOB_BYTES = 6;

  // Input item kinds
  localparam logic [2:0] FUNC_EXCEPTION    = 3'd0;
  localparam logic [2:0] FUNC_READ_COILS   = 3'd1;
  localparam logic [2:0] FUNC_READ_HOLDING = 3'd2;
  localparam logic [2:0] FUNC_WRITE_COIL   = 3'd3;
  localparam logic [2:0] FUNC_DATA         = 3'd4;

  // Modbus function codes sent in responses
  localparam logic [7:0] FC_READ_COILS   = 8'h01;
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_WRITE_COIL   = 8'h05;
  localparam logic       EXC_FLAG        = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One unit of work for the back end: up to six frame bytes, then an optional CRC
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] frame_bytes;
    logic [2:0]                nbytes;
    logic                      fresh;
    logic                      with_crc;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/mbrtu_front.sv =====
// Front end: accepts input items, tracks the open read frame and turns each item into a job.
// Depends on mbrtu_pkg.
module mbrtu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         slave_address,
  input  logic               item_accept,
  input  logic [2:0]         func,
  input  logic [6:0]         function_code,
  input  logic [7:0]         exception_code,
  input  logic [7:0]         payload_len,
  input  logic [15:0]        coil_address,
  input  logic [15:0]        coil_value,
  input  logic [7:0]         data_byte,
  output logic               push,
  output mbrtu_pkg::job_t    push_job
);
  import mbrtu_pkg::*;

  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic       job_ok;
  job_t       job;

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    job_ok         = 1'b0;
    job            = '0;
    unique case (func)
      FUNC_EXCEPTION: begin
        job_ok         = 1'b1;
        bytes_left_nxt = 8'd0;
        job.frame_bytes[0] = slave_address;
        job.frame_bytes[1] = {EXC_FLAG, function_code};
        job.frame_bytes[2] = exception_code;
        job.nbytes   = 3'd3;
        job.fresh    = 1'b1;
        job.with_crc = 1'b1;
      end
      FUNC_READ_COILS, FUNC_READ_HOLDING: begin
        job_ok         = 1'b1;
        bytes_left_nxt = payload_len;
        job.frame_bytes[0] = slave_address;
        job.frame_bytes[1] = (func == FUNC_READ_COILS) ? FC_READ_COILS : FC_READ_HOLDING;
        job.frame_bytes[2] = payload_len;
        job.nbytes   = 3'd3;
        job.fresh    = 1'b1;
        job.with_crc = (payload_len == 8'd0);
      end
      FUNC_WRITE_COIL: begin
        job_ok         = 1'b1;
        bytes_left_nxt = 8'd0;
        job.frame_bytes[0] = slave_address;
        job.frame_bytes[1] = FC_WRITE_COIL;
        job.frame_bytes[2] = coil_address[15:8];
        job.frame_bytes[3] = coil_address[7:0];
        job.frame_bytes[4] = coil_value[15:8];
        job.frame_bytes[5] = coil_value[7:0];
        job.nbytes   = 3'd6;
        job.fresh    = 1'b1;
        job.with_crc = 1'b1;
      end
      FUNC_DATA: begin
        // drop data with no frame open
        if (bytes_left_r != 8'd0) begin
          job_ok         = 1'b1;
          bytes_left_nxt = bytes_left_r - 8'd1;
          job.frame_bytes[0] = data_byte;
          job.nbytes   = 3'd1;
          job.fresh    = 1'b0;
          job.with_crc = (bytes_left_r == 8'd1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 8'd0;
    end else if (item_accept) begin
      bytes_left_r <= bytes_left_nxt;
    end
  end

  assign push     = item_accept && job_ok;
  assign push_job = job;

  a_drop_idle_data: assert property (@(posedge clk) disable iff (!rst_n)
    (item_accept && func == FUNC_DATA && bytes_left_r == 8'd0) |-> !push)
    else $error("data item queued with no frame open");

endmodule

// ===== design/mbrtu_queue.sv =====
// Short job queue between front and back ends.
// Depends on mbrtu_pkg for the job type.
module mbrtu_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mbrtu_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output mbrtu_pkg::job_t head_job
);
  import mbrtu_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count out of range");

endmodule

// ===== design/mbrtu_back.sv =====
// Back end: walks each job one byte per cycle unless the result channel stalls, keeps
// the running CRC and drives the registered result channel. Depends on mbrtu_pkg.
module mbrtu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  mbrtu_pkg::job_t job,
  output logic            job_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_tx_byte,
  output logic            out_last_of_run,
  output logic            out_frame_end
);
  import mbrtu_pkg::*;

  logic [2:0]  idx_r;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r;
  logic [7:0]  tx_byte_r;
  logic        last_r, frame_end_r;

  logic        fire, in_data, is_crc_lo, is_crc_hi, last;
  logic [7:0]  data_sel, byte_sel;
  logic [15:0] crc_base;

  always_comb begin
    unique case (idx_r)
      3'd0:    data_sel = job.frame_bytes[0];
      3'd1:    data_sel = job.frame_bytes[1];
      3'd2:    data_sel = job.frame_bytes[2];
      3'd3:    data_sel = job.frame_bytes[3];
      3'd4:    data_sel = job.frame_bytes[4];
      3'd5:    data_sel = job.frame_bytes[5];
      default: data_sel = 8'h00;
    endcase
  end

  assign fire      = job_valid && (!out_valid_r || !out_stall);
  assign in_data   = (idx_r < job.nbytes);
  assign is_crc_lo = !in_data && (idx_r == job.nbytes);
  assign is_crc_hi = !in_data && !is_crc_lo;
  assign last      = in_data ? ((3'(idx_r + 3'd1) == job.nbytes) && !job.with_crc) : is_crc_hi;
  assign crc_base  = (job.fresh && idx_r == 3'd0) ? CRC_INIT : crc_r;

  always_comb begin
    if (in_data) begin
      byte_sel = data_sel;
      crc_nxt  = crc_byte(crc_base, data_sel);
    end else if (is_crc_lo) begin
      byte_sel = crc_r[7:0];
      crc_nxt  = crc_r;
    end else begin
      // high byte closes the frame; restart the CRC
      byte_sel = crc_r[15:8];
      crc_nxt  = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      idx_r       <= last ? 3'd0 : 3'(idx_r + 3'd1);
      crc_r       <= crc_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tx_byte_r   <= byte_sel;
      last_r      <= last;
      frame_end_r <= is_crc_hi;
    end
  end

  assign job_pop         = fire && last;
  assign out_valid       = out_valid_r;
  assign out_tx_byte     = tx_byte_r;
  assign out_last_of_run = last_r;
  assign out_frame_end   = frame_end_r;

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_end_r) |-> last_r)
    else $error("frame end without last of run");

  a_idx_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (idx_r == 3'd0))
    else $error("byte index not rewound after job");

endmodule

// ===== design/modbus_rtu_response_framer_top.sv =====
// Top level of the Modbus RTU response framer: slave address register, front end,
// job queue and back end. Depends on mbrtu_pkg, mbrtu_front, mbrtu_queue, mbrtu_back.
//
// Takes one input item per cycle (the input stalls while the queue is full) and sends
// one frame byte per cycle unless the result channel stalls. A data item gives one byte
// (three with the closing CRC); a start item gives three to eight bytes and holds the
// result channel while they go out, as the back end's byte-wide CRC update emits one
// byte a cycle. With the queue empty, an item's first byte passes through a queue slot
// and the back end's output register; the queue keeps taking items while bytes drain.
module modbus_rtu_response_framer_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [6:0]  in_function_code,
  input  logic [7:0]  in_exception_code,
  input  logic [7:0]  in_payload_len,
  input  logic [15:0] in_coil_address,
  input  logic [15:0] in_coil_value,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_last_of_run,
  output logic        out_frame_end
);
  import mbrtu_pkg::*;

  logic [7:0] slave_address_r;
  logic       q_full, push, pop, head_valid;
  job_t       push_job, head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= 8'd1;
    end else if (cfg_we) begin
      slave_address_r <= cfg_wdata;
    end
  end

  assign in_stall = q_full;

  mbrtu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .slave_address  (slave_address_r),
    .item_accept    (in_valid && !q_full),
    .func           (in_func),
    .function_code  (in_function_code),
    .exception_code (in_exception_code),
    .payload_len    (in_payload_len),
    .coil_address   (in_coil_address),
    .coil_value     (in_coil_value),
    .data_byte      (in_data_byte),
    .push           (push),
    .push_job       (push_job)
  );

  mbrtu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  mbrtu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (head_valid),
    .job             (head_job),
    .job_pop         (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tx_byte     (out_tx_byte),
    .out_last_of_run (out_last_of_run),
    .out_frame_end   (out_frame_end)
  );

endmodule
